// File: src/ccm_pkg.sv
// Package for the CAN channel mode controller: event, mode and sub-state codes,
// status flag positions, per-channel state and the transfer payload structs.
// No dependencies.
package ccm_pkg;

	localparam int CHANNELS = 8;
	localparam int EV_W = 4;
	localparam int CH_W = 3;
	localparam int MASK_W = 8;
	localparam int FLAG_W = 6;

	typedef enum logic [EV_W-1:0] {
		EV_CLR_STOP = 4'd0,
		EV_SET_STOP = 4'd1,
		EV_SET_COMM = 4'd2,
		EV_SET_RESET = 4'd3,
		EV_SET_WAIT = 4'd4,
		EV_TX_START = 4'd5,
		EV_TX_DONE = 4'd6,
		EV_RX_START = 4'd7,
		EV_RX_DONE = 4'd8,
		EV_ALL_STOP = 4'd9,
		EV_ALL_RESET = 4'd10,
		EV_ALL_WAIT = 4'd11,
		EV_NOP = 4'd12
	} ev_t;

	typedef enum logic [1:0] {
		M_STOP = 2'd0,
		M_RESET = 2'd1,
		M_WAIT = 2'd2,
		M_COMM = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		C_IDLE = 2'd0,
		C_TX = 2'd1,
		C_RX = 2'd2
	} comm_t;

	localparam logic [FLAG_W-1:0] F_COMM = 6'h01;
	localparam logic [FLAG_W-1:0] F_RX = 6'h02;
	localparam logic [FLAG_W-1:0] F_TX = 6'h04;
	localparam logic [FLAG_W-1:0] F_STOP = 6'h08;
	localparam logic [FLAG_W-1:0] F_RST = 6'h10;
	localparam logic [FLAG_W-1:0] F_WAIT = 6'h20;

	typedef struct packed {
		mode_t mode;
		comm_t comm;
		mode_t req;
		logic stop_req;
		logic [FLAG_W-1:0] status;
	} chan_t;

	localparam chan_t CHAN_RESET = '{
		mode: M_STOP,
		comm: C_IDLE,
		req: M_RESET,
		stop_req: 1'b1,
		status: F_STOP | F_RST
	};

	typedef struct packed {
		logic [EV_W-1:0] mode;
		logic [CH_W-1:0] channel;
	} item_t;

	typedef struct packed {
		logic [1:0] chan_mode;
		logic [1:0] comm_state;
		logic [FLAG_W-1:0] status_flags;
		logic [MASK_W-1:0] reset_mask;
	} result_t;

	// Status after a sub-state change: mode flags kept, transfer flags rebuilt.
	function automatic logic [FLAG_W-1:0] sub_status(input logic [FLAG_W-1:0] status,
			input comm_t sub);
		logic [FLAG_W-1:0] s;
		s = (status & (F_STOP | F_RST | F_WAIT)) | F_COMM;
		if (sub == C_TX) begin
			s = s | F_TX;
		end
		if (sub == C_RX) begin
			s = s | F_RX;
		end
		return s;
	endfunction

endpackage

// File: src/ccm_lane.sv
// One channel of the CAN mode controller: its state register and next-state logic.
// Depends on ccm_pkg.
module ccm_lane (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic [ccm_pkg::EV_W-1:0]    ev,
	output ccm_pkg::chan_t              next_st,
	output logic                        pulse
);
	import ccm_pkg::*;

	chan_t state_q;

	always_comb begin
		next_st = state_q;
		pulse = 1'b0;
		unique case (ev) inside
			EV_CLR_STOP: begin
				if (state_q.mode == M_STOP) begin
					next_st.stop_req = 1'b0;
					next_st.mode = M_RESET;
					next_st.status = F_RST;
					pulse = 1'b1;
				end
			end
			EV_SET_STOP: begin
				if (state_q.mode == M_RESET) begin
					next_st.stop_req = 1'b1;
					next_st.mode = M_STOP;
					next_st.status = F_STOP | F_RST;
				end
			end
			EV_SET_COMM: begin
				if (state_q.mode == M_RESET || state_q.mode == M_WAIT) begin
					next_st.mode = M_COMM;
					next_st.req = M_COMM;
					next_st.comm = C_IDLE;
					next_st.status = sub_status(state_q.status, C_IDLE);
				end
			end
			EV_SET_RESET: begin
				if (state_q.mode == M_COMM || state_q.mode == M_WAIT) begin
					next_st.req = M_RESET;
					next_st.mode = M_RESET;
					next_st.comm = C_IDLE;
					next_st.status = F_RST;
					pulse = 1'b1;
				end
			end
			EV_SET_WAIT: begin
				if (state_q.mode == M_RESET || state_q.mode == M_COMM) begin
					next_st.req = M_WAIT;
					if (state_q.comm == C_IDLE) begin
						next_st.mode = M_WAIT;
						next_st.status = F_WAIT;
					end
				end
			end
			EV_TX_START, EV_RX_START: begin
				if (state_q.mode == M_COMM && state_q.comm == C_IDLE) begin
					next_st.comm = (ev == EV_TX_START) ? C_TX : C_RX;
					next_st.status = sub_status(state_q.status,
						(ev == EV_TX_START) ? C_TX : C_RX);
				end
			end
			EV_TX_DONE, EV_RX_DONE: begin
				if (state_q.mode == M_COMM &&
						state_q.comm == ((ev == EV_TX_DONE) ? C_TX : C_RX)) begin
					next_st.comm = C_IDLE;
					next_st.status = sub_status(state_q.status, C_IDLE);
					if (state_q.req == M_WAIT) begin
						next_st.mode = M_WAIT;
						next_st.status = F_WAIT;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CHAN_RESET;
		end else if (en) begin
			state_q <= next_st;
		end
	end

`ifndef ASSERT_OFF
	a_idle_outside_comm: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode != M_COMM |-> state_q.comm == C_IDLE)
		else $error("channel holds a transfer outside comm mode");
	a_stop_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode == M_STOP |-> state_q.stop_req && state_q.status == (F_STOP | F_RST))
		else $error("stop mode without stop request or stop flags");
	a_pulse_to_reset: assert property (@(posedge clk) disable iff (!arst_n)
		en && pulse |=> state_q.mode == M_RESET && state_q.status == F_RST)
		else $error("register reset pulse without entering reset mode");
`endif

endmodule

// File: src/can_channel_mode_fsm.sv
// CAN channel mode controller: event decode, channel lanes and the result register.
// Depends on ccm_pkg and ccm_lane.
//
// The item channel carries one event and a channel number per transfer. Events
// zero to eight act on the addressed channel; the broadcast events act on every
// channel at once. The result channel returns, for every item, the mode,
// sub-state and status flags of the addressed channel after the event, plus a
// mask of channels whose registers were reset by it. A channel number at or
// above the channel count reports zero state.
// On the way from item transfer to result transfer, the item lands in the input
// register, and the lane update is then loaded into the result register, whose valid
// rises with it. One item is taken every cycle while the item side is not stalled.
// When the receiver stalls, the result register holds its transfer and the item
// side stalls only once the input register is also full, so two items can be
// outstanding. After reset every channel is in stop mode with its stop request
// set and the stop and reset flags raised; no result is pending.
module can_channel_mode_fsm (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  ccm_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output ccm_pkg::result_t result
);
	import ccm_pkg::*;

	logic s1_valid_q;
	item_t item_s1;
	logic adv;
	logic [EV_W-1:0] lane_ev [CHANNELS];
	chan_t lane_next [CHANNELS];
	logic [CHANNELS-1:0] lane_pulse;
	result_t res_d;

	assign adv = s1_valid_q && !(result_valid && result_stall);
	assign item_stall = s1_valid_q && result_valid && result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!item_stall) begin
			s1_valid_q <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
		always_comb begin
			lane_ev[c] = EV_NOP;
			if (item_s1.mode <= EV_RX_DONE) begin
				if (item_s1.channel == CH_W'(c)) begin
					lane_ev[c] = item_s1.mode;
				end
			end else begin
				case (item_s1.mode)
					EV_ALL_STOP: lane_ev[c] = EV_SET_STOP;
					EV_ALL_RESET: lane_ev[c] = EV_SET_RESET;
					EV_ALL_WAIT: lane_ev[c] = EV_SET_WAIT;
					default: lane_ev[c] = EV_NOP;
				endcase
			end
		end

		ccm_lane u_lane (
			.clk(clk),
			.arst_n(arst_n),
			.en(adv),
			.ev(lane_ev[c]),
			.next_st(lane_next[c]),
			.pulse(lane_pulse[c])
		);
	end

	always_comb begin
		res_d = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			if (item_s1.channel == CH_W'(c)) begin
				res_d.chan_mode = lane_next[c].mode;
				res_d.comm_state = lane_next[c].comm;
				res_d.status_flags = lane_next[c].status;
			end
			res_d.reset_mask[c] = lane_pulse[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (!(result_valid && result_stall)) begin
			result_valid <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result <= res_d;
		end
	end

`ifndef ASSERT_OFF
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> s1_valid_q && result_valid && result_stall)
		else $error("item side stalled while the result register can move");
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> result_valid)
		else $error("processed item produced no result");
	a_single_reset: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s1.mode <= EV_RX_DONE |=> $countones(result.reset_mask) <= 1)
		else $error("channel event reset more than one channel");
`endif

endmodule
